/* hw/rtl/sllb_pkg.sv */
`default_nettype none

package sllb_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int LINES_DEF    = 224;
  localparam int PER_LINE_DEF = 8;
  localparam int SPRITES_DEF  = 64;

  // Fixed geometry
  localparam int OUT_SLOTS    = 8;
  localparam int END_Y        = 208;
  localparam int WRAP_ABOVE   = 224;
  localparam int WIDE_LINES   = 224;
  localparam int NARROW_LINES = 192;
  localparam int TALL_H       = 16;
  localparam int SHORT_H      = 8;
  localparam int SPR_W        = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TALL_SPRITES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_SCREEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT  = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [SPR_W-1:0] sprite_number;
    logic [7:0]       sprite_y;
    logic [7:0]       line_number;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       line_count;
    logic             overflow;
    logic [SPR_W-1:0] slot_0;
    logic [SPR_W-1:0] slot_1;
    logic [SPR_W-1:0] slot_2;
    logic [SPR_W-1:0] slot_3;
    logic [SPR_W-1:0] slot_4;
    logic [SPR_W-1:0] slot_5;
    logic [SPR_W-1:0] slot_6;
    logic [SPR_W-1:0] slot_7;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic eval;
    logic fill_rd;
    logic fill_wr;
    logic take_count;
    logic slot_rd;
    logic slot_cap;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic add_go;
    logic wr_last;
    logic rd_none;
    logic slot_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/sllb_ctrl.sv */
`default_nettype none

module sllb_ctrl import sllb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_op_i,
  output logic            in_ready_o,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_EVAL = 4'd1;
  localparam logic [3:0] S_ADD_RD   = 4'd2;
  localparam logic [3:0] S_ADD_WR   = 4'd3;
  localparam logic [3:0] S_RD_FILL  = 4'd4;
  localparam logic [3:0] S_RD_CNT   = 4'd5;
  localparam logic [3:0] S_RD_SLOT  = 4'd6;
  localparam logic [3:0] S_RD_CAP   = 4'd7;
  localparam logic [3:0] S_RD_DONE  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            OP_CLEAR: cmd_o.clear = 1'b1;
            OP_ADD: begin
              cmd_o.load = 1'b1;
              state_d    = S_ADD_EVAL;
            end
            OP_READ: begin
              cmd_o.load = 1'b1;
              state_d    = S_RD_FILL;
            end
            default: ;
          endcase
        end
      end
      S_ADD_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.add_go ? S_ADD_RD : S_IDLE;
      end
      S_ADD_RD: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.fill_wr = 1'b1;
        state_d       = sts_i.wr_last ? S_IDLE : S_ADD_RD;
      end
      S_RD_FILL: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = S_RD_CNT;
      end
      S_RD_CNT: begin
        cmd_o.take_count = 1'b1;
        state_d          = sts_i.rd_none ? S_RD_DONE : S_RD_SLOT;
      end
      S_RD_SLOT: begin
        cmd_o.slot_rd = 1'b1;
        state_d       = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd_o.slot_cap = 1'b1;
        state_d        = sts_i.slot_last ? S_RD_DONE : S_RD_SLOT;
      end
      S_RD_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sllb_dp.sv */
`default_nettype none

module sllb_dp import sllb_pkg::*; #(
  parameter int LINES    = LINES_DEF,
  parameter int PER_LINE = PER_LINE_DEF,
  parameter int SPRITES  = SPRITES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire in_item_t              in_item_i,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o
);

  localparam int LineW     = $clog2(LINES);
  localparam int CurW      = LineW + 1;
  localparam int FillW     = $clog2(PER_LINE + 2);
  localparam int SlotDepth = LINES * PER_LINE;
  localparam int SlotAw    = $clog2(SlotDepth);
  localparam int JW        = $clog2(OUT_SLOTS);
  localparam int VisWide   = (LINES < WIDE_LINES) ? LINES : WIDE_LINES;
  localparam int VisNarrow = (LINES < NARROW_LINES) ? LINES : NARROW_LINES;

  // Configuration registers
  logic       tall_q, wide_q;
  logic [7:0] view_top_q, view_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tall_q        <= 1'b0;
      wide_q        <= 1'b0;
      view_top_q    <= 8'd24;
      view_height_q <= 8'd144;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TALL_SPRITES: tall_q        <= cfg_data_i[0];
        CFG_WIDE_SCREEN:  wide_q        <= cfg_data_i[0];
        CFG_VIEW_TOP:     view_top_q    <= cfg_data_i;
        CFG_VIEW_HEIGHT:  view_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item registers
  logic [SPR_W-1:0] num_q;
  logic [7:0]       y_q;
  logic [CurW-1:0]  cur_q, stop_q;
  logic             ended_q;

  // Range of lines covered by the sprite
  logic signed [9:0] y_s, first_s, stop_s, first_c, stop_c;
  logic signed [9:0] vmin_s, vmax_s, height_s, vis_s;
  logic              num_ok, term, skip;

  always_comb begin
    y_s      = (y_q > 8'(WRAP_ABOVE)) ? $signed({2'b00, y_q}) - 10'sd256
                                      : $signed({2'b00, y_q});
    height_s = tall_q ? 10'(TALL_H) : 10'(SHORT_H);
    vis_s    = wide_q ? 10'(VisWide) : 10'(VisNarrow);
    first_s  = y_s + 10'sd1;
    stop_s   = first_s + height_s;
    first_c  = (first_s < 10'sd0) ? 10'sd0 : first_s;
    stop_c   = (stop_s > vis_s) ? vis_s : stop_s;
    vmin_s   = wide_q ? 10'sd0 : $signed({2'b00, view_top_q});
    vmax_s   = wide_q ? 10'(WIDE_LINES)
                      : $signed({2'b00, view_top_q}) + $signed({2'b00, view_height_q});
    num_ok   = {1'b0, num_q} < 7'(SPRITES);
    term     = !wide_q && (y_q == 8'(END_Y));
    skip     = (stop_c <= vmin_s) || (first_c >= vmax_s) || (first_c >= stop_c);
  end

  assign sts_o.add_go  = !ended_q && num_ok && !term && !skip;
  assign sts_o.wr_last = (CurW'(cur_q + 1'b1) == stop_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= in_item_i.sprite_number;
      y_q   <= in_item_i.sprite_y;
      cur_q <= CurW'(in_item_i.line_number);
    end else if (cmd_i.eval) begin
      cur_q  <= first_c[CurW-1:0];
      stop_q <= stop_c[CurW-1:0];
    end else if (cmd_i.fill_wr) begin
      cur_q <= CurW'(cur_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b0;
    end else if (cmd_i.clear) begin
      ended_q <= 1'b0;
    end else if (cmd_i.eval && !ended_q && num_ok && term) begin
      ended_q <= 1'b1;
    end
  end

  // Line fill memory; valid bits stand in for the cleared state
  logic [FillW-1:0] fill_mem [LINES];
  logic [LINES-1:0] fill_vld_q;
  logic [FillW-1:0] fill_rd_q, fill_eff, fill_new;
  logic             vld_rd_q, oob;
  logic [LineW-1:0] fill_addr;

  assign fill_addr = cur_q[LineW-1:0];
  assign oob       = (cur_q >= CurW'(LINES));
  assign fill_eff  = (vld_rd_q && !oob) ? fill_rd_q : '0;
  assign fill_new  = (fill_eff < FillW'(PER_LINE + 1)) ? FillW'(fill_eff + 1'b1) : fill_eff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_rd) begin
      fill_rd_q <= fill_mem[fill_addr];
      vld_rd_q  <= fill_vld_q[fill_addr];
    end
    if (cmd_i.fill_wr) begin
      fill_mem[fill_addr] <= fill_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_vld_q <= '0;
    end else if (cmd_i.clear) begin
      fill_vld_q <= '0;
    end else if (cmd_i.fill_wr) begin
      fill_vld_q[fill_addr] <= 1'b1;
    end
  end

  // Slot memory, one row of PER_LINE entries per line
  logic [SPR_W-1:0]  slot_mem [SlotDepth];
  logic [SPR_W-1:0]  slot_rd_q;
  logic [SlotAw-1:0] line_base, slot_wr_addr, slot_rd_addr;
  logic [JW-1:0]     j_q;

  assign line_base    = SlotAw'(fill_addr) * SlotAw'(PER_LINE);
  assign slot_wr_addr = line_base + SlotAw'(fill_eff);
  assign slot_rd_addr = line_base + SlotAw'(j_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_wr && (fill_eff < FillW'(PER_LINE))) begin
      slot_mem[slot_wr_addr] <= num_q;
    end
    if (cmd_i.slot_rd) begin
      slot_rd_q <= slot_mem[slot_rd_addr];
    end
  end

  // Read result assembly
  logic [7:0]       cnt8;
  logic             ovf;
  logic [3:0]       rd_cnt_q, rd_num_q;
  logic             rd_ovf_q;
  logic [SPR_W-1:0] slots_q [OUT_SLOTS];

  assign ovf  = (fill_eff > FillW'(PER_LINE));
  assign cnt8 = ovf ? 8'(PER_LINE) : 8'(fill_eff);

  assign sts_o.rd_none   = (cnt8 == 8'd0);
  assign sts_o.slot_last = (4'({1'b0, j_q} + 1'b1) == rd_num_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_count) begin
      rd_cnt_q <= (cnt8 > 8'd15) ? 4'd15 : cnt8[3:0];
      rd_ovf_q <= ovf;
      rd_num_q <= (cnt8 > 8'(OUT_SLOTS)) ? 4'(OUT_SLOTS) : cnt8[3:0];
      j_q      <= '0;
      slots_q  <= '{default: '0};
    end else if (cmd_i.slot_cap) begin
      slots_q[j_q] <= slot_rd_q;
      j_q          <= JW'(j_q + 1'b1);
    end
  end

  // Output register
  out_item_t out_q;
  logic      out_valid_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.line_count <= rd_cnt_q;
      out_q.overflow   <= rd_ovf_q;
      out_q.slot_0     <= slots_q[0];
      out_q.slot_1     <= slots_q[1];
      out_q.slot_2     <= slots_q[2];
      out_q.slot_3     <= slots_q[3];
      out_q.slot_4     <= slots_q[4];
      out_q.slot_5     <= slots_q[5];
      out_q.slot_6     <= slots_q[6];
      out_q.slot_7     <= slots_q[7];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sprite_line_list_builder_top.sv */
// Sprite line list builder. Send a clear item at the start of each frame, then one add item
// per sprite Y entry in sprite order, then read items to fetch each line's count, overflow
// flag and first eight sprite numbers. Items are taken one at a time; an add walks the
// covered lines one at a time with a read-modify-write of the line fill memory, and a read
// does one slot memory read per stored slot. A finished read result waits in the output
// register while the next item is already accepted. Line counts reset to empty through
// per-line valid bits, so no clearing pass is needed and a clear item takes effect at
// once. Write configuration only while no item is in flight; the block takes every write
// at once.
`default_nettype none

module sprite_line_list_builder_top import sllb_pkg::*; #(
  parameter int LINES    = LINES_DEF,
  parameter int PER_LINE = PER_LINE_DEF,
  parameter int SPRITES  = SPRITES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input items
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_item_i,
  // Result items, one per read item
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each item: clear, add (evaluate range, walk lines), read (fill, slots)
  sllb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_item_i.op),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold configuration, line memories and the output register
  sllb_dp #(
    .LINES    (LINES),
    .PER_LINE (PER_LINE),
    .SPRITES  (SPRITES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/sllb_checker.sv */
`default_nettype none

module sllb_checker import sllb_pkg::*; #(
  parameter int PER_LINE = PER_LINE_DEF
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  localparam int MaxCnt = (PER_LINE > 15) ? 15 : PER_LINE;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Count never exceeds the per-line capacity
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.line_count <= 4'(MaxCnt))
    else $error("line count above capacity");

  // Overflow only on a full line
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.overflow |-> out_item_o.line_count == 4'(MaxCnt))
    else $error("overflow on a line that is not full");

  // Slot 7 reads as zero when the line holds fewer than eight sprites
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.line_count < 4'd8) |-> out_item_o.slot_7 == '0)
    else $error("unused slot not zero");

  // An accepted add item deasserts in_ready in the following cycle
  a_add_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.op == OP_ADD) |=> !in_ready_o)
    else $error("add item did not occupy the block");

endmodule

bind sprite_line_list_builder_top sllb_checker #(.PER_LINE(PER_LINE)) u_sllb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

/* dv/sprite_line_list_builder_top_tb.sv */
`default_nettype none

module sprite_line_list_builder_top_tb;
  import sllb_pkg::*;

  // Op code the block ignores: no state change, no result
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int SETTLE      = 40;    // covers the longest add (tall sprites)
  localparam int STALL_LIMIT = 5000;  // cycles with no handshake before giving up
  localparam int HOLD_LEN    = 400;   // long receiver hold-off
  localparam int PHASE_ITEMS = 260;
  localparam int MAX_REPORTS = 60;

  // Bit offset of slot k inside a result item; slot_0 sits highest
  function automatic int slot_lsb(int k);
    return (OUT_SLOTS - 1 - k) * SPR_W;
  endfunction

  // Line list predictor and store of pending read results
  class line_list_scoreboard;
    bit               tall_sprites;
    bit               wide_screen;
    int               view_top;
    int               view_height;
    int               line_fill [LINES_DEF];
    logic [SPR_W-1:0] line_slots [LINES_DEF][PER_LINE_DEF];
    bit               list_ended;
    out_item_t        pending_reads [$];
    int               reads_seen;
    int               errors;

    function new();
      tall_sprites = 1'b0;
      wide_screen  = 1'b0;
      view_top     = 24;
      view_height  = 144;
      foreach (line_fill[i]) line_fill[i] = 0;
      list_ended   = 1'b0;
      reads_seen   = 0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TALL_SPRITES: tall_sprites = data[0];
        CFG_WIDE_SCREEN:  wide_screen  = data[0];
        CFG_VIEW_TOP:     view_top     = data;
        CFG_VIEW_HEIGHT:  view_height  = data;
        default: ;
      endcase
    endfunction

    function void place_sprite(int num, int y);
      int height, visible, vmin, vmax, first, stop, ln;
      height  = tall_sprites ? TALL_H : SHORT_H;
      visible = wide_screen ? WIDE_LINES : NARROW_LINES;
      if (list_ended || num >= SPRITES_DEF) return;
      if (!wide_screen && y == END_Y) begin
        list_ended = 1'b1;
        return;
      end
      if (visible > LINES_DEF) visible = LINES_DEF;
      if (y > WRAP_ABOVE) y -= 256;
      first = y + 1;
      stop  = first + height;
      if (first < 0) first = 0;
      if (stop > visible) stop = visible;
      vmin = wide_screen ? 0 : view_top;
      vmax = wide_screen ? WIDE_LINES : view_top + view_height;
      if (stop <= vmin || first >= vmax) return;
      for (ln = first; ln < stop; ln++) begin
        if (line_fill[ln] < PER_LINE_DEF) begin
          line_slots[ln][line_fill[ln]] = SPR_W'(num);
          line_fill[ln]++;
        end else if (line_fill[ln] == PER_LINE_DEF) begin
          line_fill[ln] = PER_LINE_DEF + 1;
        end
      end
    endfunction

    function out_item_t line_result(int ln);
      logic [$bits(out_item_t)-1:0] v;
      int cnt, k;
      v = '0;
      if (ln < LINES_DEF) begin
        cnt = (line_fill[ln] > PER_LINE_DEF) ? PER_LINE_DEF : line_fill[ln];
        for (k = 0; k < OUT_SLOTS && k < cnt; k++) v[slot_lsb(k) +: SPR_W] = line_slots[ln][k];
        v = out_item_t'(v);
        return line_fields(v, cnt, line_fill[ln] > PER_LINE_DEF);
      end
      return out_item_t'(v);
    endfunction

    function out_item_t line_fields(out_item_t r, int cnt, bit ovf);
      r.line_count = (cnt > 15) ? 4'd15 : 4'(cnt);
      r.overflow   = ovf;
      return r;
    endfunction

    function void note_item(in_item_t it);
      case (it.op)
        OP_CLEAR: begin
          foreach (line_fill[i]) line_fill[i] = 0;
          list_ended = 1'b0;
        end
        OP_ADD:  place_sprite(it.sprite_number, it.sprite_y);
        OP_READ: pending_reads.push_back(line_result(it.line_number));
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      logic [$bits(out_item_t)-1:0] gv, wv;
      int k;
      if (pending_reads.size() == 0) begin
        report($sformatf("result %h arrived with no read pending", got));
        return;
      end
      want = pending_reads.pop_front();
      gv = got;
      wv = want;
      if (got.line_count != want.line_count)
        report($sformatf("read %0d line_count got %0d want %0d",
                         reads_seen, got.line_count, want.line_count));
      if (got.overflow != want.overflow)
        report($sformatf("read %0d overflow got %0d want %0d",
                         reads_seen, got.overflow, want.overflow));
      for (k = 0; k < OUT_SLOTS; k++) begin
        if (gv[slot_lsb(k) +: SPR_W] != wv[slot_lsb(k) +: SPR_W])
          report($sformatf("read %0d slot_%0d got %0d want %0d", reads_seen, k,
                           gv[slot_lsb(k) +: SPR_W], wv[slot_lsb(k) +: SPR_W]));
      end
      reads_seen++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;

  line_list_scoreboard sb;

  int idle_pct  = 0;   // chance per cycle that the sender holds back
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  int hold_req  = 0;   // bumped by the stimulus to ask for a long hold-off
  int hold_ack  = 0;   // owned by the receiver process
  int sent      = 0;   // items accepted, not counting ignored op codes
  int quiet     = 0;

  sprite_line_list_builder_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both handshakes at the rising edge; predict on accepted items,
  // check accepted results against the oldest pending read.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  // Watchdog: count cycles in which no item, result or register write moves.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls at the current rate, or a long hold-off on request.
  // The hold-off is counted here so the sender keeps offering items meanwhile.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Random fill for every field; callers override what the op uses
  function automatic in_item_t rnd_item(logic [1:0] op);
    in_item_t it;
    it.op            = op;
    it.sprite_number = SPR_W'($urandom);
    it.sprite_y      = 8'($urandom);
    it.line_number   = 8'($urandom);
    return it;
  endfunction

  // Offer one item after a random gap; hold valid and payload until accepted.
  // Valid stays high afterwards so a following item goes out back to back.
  task automatic offer(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.op != OP_UNUSED) sent++;
  endtask

  task automatic send_clear();
    offer(rnd_item(OP_CLEAR));
  endtask

  task automatic send_add(int num, int y);
    in_item_t it;
    it = rnd_item(OP_ADD);
    it.sprite_number = SPR_W'(num);
    it.sprite_y      = 8'(y);
    offer(it);
  endtask

  task automatic send_read(int ln);
    in_item_t it;
    it = rnd_item(OP_READ);
    it.line_number = 8'(ln);
    offer(it);
  endtask

  // Drop valid, wait for every pending read, then let a trailing add finish.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all four registers, back to back; only call while the block is idle.
  task automatic write_regs(int tall, int wide, int top, int height);
    logic [CFG_DATA_W-1:0] vals [1 << CFG_IDX_W];
    vals[CFG_TALL_SPRITES] = CFG_DATA_W'(tall);
    vals[CFG_WIDE_SCREEN]  = CFG_DATA_W'(wide);
    vals[CFG_VIEW_TOP]     = CFG_DATA_W'(top);
    vals[CFG_VIEW_HEIGHT]  = CFG_DATA_W'(height);
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      @(negedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(CFG_IDX_W'(i), vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pick a setting; the viewport often sits at its extremes.
  task automatic pick_config();
    int top, height;
    case ($urandom_range(3))
      0:       top = 0;
      1:       top = 223;
      default: top = $urandom_range(223);
    endcase
    case ($urandom_range(7))
      0:       height = 0;
      1, 2:    height = 224;
      default: height = $urandom_range(224);
    endcase
    write_regs($urandom_range(1), ($urandom_range(99) < 40), top, height);
  endtask

  // One frame: clear, sprite entries in order clustered around a base line so
  // lines overflow, then reads around that base. Noise and broken sequences
  // (skipped clear, stray clear, stray read, unused op) are mixed in.
  task automatic run_frame(bit long_hold);
    int n_adds, n_reads, base, num, y, r, i;
    n_adds  = ($urandom_range(9) == 0) ? 64 : $urandom_range(2, 40);
    n_reads = $urandom_range(4, 16);
    base    = $urandom_range(200);
    if ($urandom_range(9) != 0) send_clear();
    for (i = 0; i < n_adds; i++) begin
      r = $urandom_range(99);
      if (r < 2) offer(rnd_item(OP_UNUSED));
      else if (r < 4) send_read($urandom_range(255));
      else if (r == 4) send_clear();
      // change registers partway through the sprite entries now and then
      if (i == n_adds / 2 && $urandom_range(9) == 0) begin
        quiesce();
        pick_config();
      end
      r = $urandom_range(99);
      if (r < 60)      y = base + $urandom_range(12);
      else if (r < 70) y = $urandom_range(WRAP_ABOVE + 1, 255);
      else if (r < 75) y = END_Y;
      else             y = $urandom_range(255);
      num = ($urandom_range(9) == 0) ? $urandom_range(SPRITES_DEF - 1) : i;
      send_add(num, y);
    end
    // long hold-off: the block fills up and stalls its input
    if (long_hold) hold_req++;
    for (i = 0; i < n_reads; i++) begin
      if ($urandom_range(99) < 75) send_read(base + $urandom_range(28));
      else send_read($urandom_range(255));
    end
  endtask

  initial begin
    int target;
    bit first_frame;
    sb       = new();
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: 8-line sprites, 192 lines, viewport 24..167.
    send_clear();
    // nine sprites on lines 31..38: the ninth overflows them, sprite 63 among them
    for (int i = 0; i < 9; i++) send_add((i == 1) ? SPRITES_DEF - 1 : i, 30);
    send_add(9, 255);              // wraps to -1: lines 0..7, above the viewport
    send_add(10, WRAP_ABOVE);      // no wrap: starts below the visible lines
    send_add(11, WRAP_ABOVE + 1);  // wraps to -31: ends above line 0
    send_read(31);
    send_read(39);
    send_read(LINES_DEF);          // beyond the last line
    offer(rnd_item(OP_UNUSED));
    send_add(12, END_Y);           // end of list
    send_add(13, 100);             // dropped after the end marker
    send_read(101);
    quiesce();
    // wide mode, tall sprites: the end marker still stands until a clear
    write_regs(1, 1, 0, 0);
    send_add(14, 50);
    send_read(51);
    send_clear();
    send_add(SPRITES_DEF - 1, 255);  // lines 0..15
    send_add(5, END_Y);              // ordinary entry in wide mode, clamped at 223
    send_read(0);
    send_read(14);
    send_read(LINES_DEF - 1);

    // Random part in four phases of sender and receiver pacing.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 88; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      target = sent + PHASE_ITEMS;
      first_frame = 1'b1;
      while (sent < target) begin
        // pause until every read has come back, then maybe retune
        if (first_frame || $urandom_range(1) == 1) begin
          quiesce();
          pick_config();
        end
        run_frame(ph == 0 && first_frame);
        first_frame = 1'b0;
      end
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
